FILE: rtl/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Shared widths, request codes and queue entry type for the rational
// arithmetic reduce core.
// ----------------------------------------------------------------------------
package rar_pkg;

   // Operand width and derived result widths
   localparam int WIDTH  = 16;
   localparam int MAG_W  = 2 * WIDTH;
   localparam int NUM_W  = 2 * WIDTH + 1;
   localparam int DEN_W  = 2 * WIDTH;
   localparam int CNT_W  = $clog2(MAG_W);
   localparam int K_W    = $clog2(MAG_W + 1);

   // Queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Request codes
   localparam logic [2:0] OP_REDUCE   = 3'd0;
   localparam logic [2:0] OP_ADD      = 3'd1;
   localparam logic [2:0] OP_SUB      = 3'd2;
   localparam logic [2:0] OP_MUL      = 3'd3;
   localparam logic [2:0] OP_DIV      = 3'd4;
   localparam logic [2:0] OP_COMPARE  = 3'd5;

   // What the back end has to do with an entry
   typedef enum logic [1:0] {
      KIND_ARITH = 2'd0,
      KIND_CMP   = 2'd1,
      KIND_ERR   = 2'd2
   } rar_kind_type;

   typedef struct packed {
      rar_kind_type       kind;
      logic               greater;
      logic               num_neg;
      logic [MAG_W-1:0]   num_mag;
      logic               den_neg;
      logic [MAG_W-1:0]   den_mag;
   } rar_entry_type;

   // Front to queue write port
   typedef struct packed {
      logic          valid;
      rar_entry_type entry;
   } rar_wr_type;

endpackage

FILE: rtl/rational_arith_reduce_core.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce_core
// Exact reduce, add, subtract, multiply, divide and compare on two signed
// fractions, with the result divided down by the gcd of its magnitudes.
// ----------------------------------------------------------------------------
// Each request is taken by a front end that checks the operands and forms
// the exact cross products, then waits in a two-entry queue for the back
// end. Compare and error transactions go straight to the output state of
// the back end. Arithmetic transactions run a binary gcd loop on the 32-bit
// magnitudes and then two bit-serial dividers that run side by side. The
// front end takes the next request while the back end works, as long as
// the queue has room, and a finished result waits in the output register
// while the back end starts on the next entry.
module rational_arith_reduce_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [2:0]                    req_type,
   input  logic [rar_pkg::WIDTH-1:0]     req_a_num,
   input  logic [rar_pkg::WIDTH-1:0]     req_a_den,
   input  logic [rar_pkg::WIDTH-1:0]     req_b_num,
   input  logic [rar_pkg::WIDTH-1:0]     req_b_den,
   output logic                          empty,
   input  logic                          pop,
   output logic [rar_pkg::NUM_W-1:0]     rsp_res_num,
   output logic [rar_pkg::DEN_W-1:0]     rsp_res_den,
   output logic                          rsp_a_greater,
   output logic                          rsp_error
);
   import rar_pkg::*;

   rar_wr_type    q_wr;
   rar_entry_type q_rd_entry;
   logic          q_full, q_empty, q_pop;

   // Front end: accept and classify
   rar_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_type  (req_type),
      .req_a_num (req_a_num),
      .req_a_den (req_a_den),
      .req_b_num (req_b_num),
      .req_b_den (req_b_den),
      .q_full    (q_full),
      .q_wr      (q_wr)
   );

   // Decoupling queue
   rar_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .q_wr       (q_wr),
      .q_full     (q_full),
      .q_pop      (q_pop),
      .q_empty    (q_empty),
      .q_rd_entry (q_rd_entry)
   );

   // Back end: gcd, divide, output register
   rar_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .q_rd_entry    (q_rd_entry),
      .empty         (empty),
      .pop           (pop),
      .rsp_res_num   (rsp_res_num),
      .rsp_res_den   (rsp_res_den),
      .rsp_a_greater (rsp_a_greater),
      .rsp_error     (rsp_error)
   );

   // Front never writes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_wr.valid |-> !q_full)
      else $error("queue write while full");

   // Back end only pops a queue that holds entries
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue pop while empty");

   // An error transaction carries zero fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_error) |->
         (rsp_res_num == '0 && rsp_res_den == '0 && !rsp_a_greater))
      else $error("error result with nonzero fields");

   // A good result with a nonzero numerator never has a zero denominator
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_error && rsp_res_num != '0) |-> (rsp_res_den != '0))
      else $error("nonzero numerator over zero denominator");

endmodule

FILE: rtl/rar_front.sv
// ----------------------------------------------------------------------------
// rar_front
// Accepts a request, checks operands, forms the exact cross products and
// the signed numerator/denominator, then writes one entry into the queue.
// ----------------------------------------------------------------------------
module rar_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [2:0]                 req_type,
   input  logic [rar_pkg::WIDTH-1:0]  req_a_num,
   input  logic [rar_pkg::WIDTH-1:0]  req_a_den,
   input  logic [rar_pkg::WIDTH-1:0]  req_b_num,
   input  logic [rar_pkg::WIDTH-1:0]  req_b_den,
   input  logic                       q_full,
   output rar_pkg::rar_wr_type        q_wr
);
   import rar_pkg::*;

   typedef enum logic [2:0] {
      FR_IDLE = 3'b001,
      FR_MUL  = 3'b010,
      FR_PUSH = 3'b100
   } fr_state_type;

   fr_state_type     state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic             err_ff, err_in;
   logic [WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [WIDTH-1:0] an_in, ad_in, bn_in, bd_in;
   logic             an_neg_ff, ad_neg_ff, bn_neg_ff, bd_neg_ff;
   logic             an_neg_in, ad_neg_in, bn_neg_in, bd_neg_in;
   logic [MAG_W-1:0] p1_ff, p2_ff, p3_ff, p1_in, p2_in, p3_in;
   logic             s1_ff, s2_ff, s3_ff, s1_in, s2_in, s3_in;

   logic [WIDTH-1:0] an_mag, ad_mag, bn_mag, bd_mag;
   logic [WIDTH-1:0] f1a, f1b, f2a, f2b, f3a, f3b;
   logic             g1a, g1b, g2a, g2b, g3a, g3b;
   logic             sub_op, t1neg, t2neg, sum_neg;
   logic [MAG_W-1:0] sum_mag;
   rar_entry_type    ent;

   // Two's complement to magnitude
   assign an_mag = req_a_num[WIDTH-1] ? (~req_a_num + 1'b1) : req_a_num;
   assign ad_mag = req_a_den[WIDTH-1] ? (~req_a_den + 1'b1) : req_a_den;
   assign bn_mag = req_b_num[WIDTH-1] ? (~req_b_num + 1'b1) : req_b_num;
   assign bd_mag = req_b_den[WIDTH-1] ? (~req_b_den + 1'b1) : req_b_den;

   // Factor selection per request
   always_comb begin
      f1a = an_ff; f1b = bd_ff; g1a = an_neg_ff; g1b = bd_neg_ff;
      f2a = ad_ff; f2b = bn_ff; g2a = ad_neg_ff; g2b = bn_neg_ff;
      f3a = ad_ff; f3b = bd_ff; g3a = ad_neg_ff; g3b = bd_neg_ff;
      case (op_ff)
         OP_REDUCE: begin
            f1b = WIDTH'(1); g1b = 1'b0;
            f2a = '0;
            f3b = WIDTH'(1); g3b = 1'b0;
         end
         OP_MUL: begin
            f1b = bn_ff; g1b = bn_neg_ff;
            f2a = '0;
         end
         OP_DIV: begin
            f2a = '0;
            f3b = bn_ff; g3b = bn_neg_ff;
         end
         default: begin
         end
      endcase
   end

   // Signed combine of the two numerator terms
   assign sub_op = (op_ff == OP_SUB) || (op_ff == OP_COMPARE);
   assign t1neg  = (p1_ff != '0) && s1_ff;
   assign t2neg  = (p2_ff != '0) && (s2_ff ^ sub_op);
   always_comb begin
      if (t1neg == t2neg) begin
         sum_mag = p1_ff + p2_ff;
         sum_neg = t1neg;
      end else if (p1_ff >= p2_ff) begin
         sum_mag = p1_ff - p2_ff;
         sum_neg = t1neg;
      end else begin
         sum_mag = p2_ff - p1_ff;
         sum_neg = t2neg;
      end
      if (sum_mag == '0) sum_neg = 1'b0;
   end

   // Queue entry
   always_comb begin
      if (err_ff) ent.kind = KIND_ERR;
      else if (op_ff == OP_COMPARE) ent.kind = KIND_CMP;
      else ent.kind = KIND_ARITH;
      ent.greater = (sum_mag != '0) && (sum_neg == (ad_neg_ff ^ bd_neg_ff));
      ent.num_neg = sum_neg;
      ent.num_mag = sum_mag;
      ent.den_neg = (p3_ff != '0) && s3_ff;
      ent.den_mag = p3_ff;
   end

   assign full        = (state_ff != FR_IDLE);
   assign q_wr.valid  = (state_ff == FR_PUSH) && !q_full;
   assign q_wr.entry  = ent;

   // Next state and data
   always_comb begin
      state_in = state_ff;
      op_in = op_ff; err_in = err_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      an_neg_in = an_neg_ff; ad_neg_in = ad_neg_ff;
      bn_neg_in = bn_neg_ff; bd_neg_in = bd_neg_ff;
      p1_in = p1_ff; p2_in = p2_ff; p3_in = p3_ff;
      s1_in = s1_ff; s2_in = s2_ff; s3_in = s3_ff;
      case (state_ff)
         FR_IDLE: begin
            if (push) begin
               op_in = req_type;
               err_in = (req_type > OP_COMPARE) || (ad_mag == '0) ||
                        ((req_type != OP_REDUCE) && (bd_mag == '0)) ||
                        ((req_type == OP_DIV) && (bn_mag == '0));
               an_in = an_mag; ad_in = ad_mag; bn_in = bn_mag; bd_in = bd_mag;
               an_neg_in = req_a_num[WIDTH-1];
               ad_neg_in = req_a_den[WIDTH-1];
               bn_neg_in = req_b_num[WIDTH-1];
               bd_neg_in = req_b_den[WIDTH-1];
               state_in = FR_MUL;
            end
         end
         FR_MUL: begin
            p1_in = f1a * f1b; s1_in = g1a ^ g1b;
            p2_in = f2a * f2b; s2_in = g2a ^ g2b;
            p3_in = f3a * f3b; s3_in = g3a ^ g3b;
            state_in = FR_PUSH;
         end
         FR_PUSH: begin
            if (!q_full) state_in = FR_IDLE;
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FR_IDLE;
      else state_ff <= state_in;
      op_ff <= op_in; err_ff <= err_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      an_neg_ff <= an_neg_in; ad_neg_ff <= ad_neg_in;
      bn_neg_ff <= bn_neg_in; bd_neg_ff <= bd_neg_in;
      p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in;
      s1_ff <= s1_in; s2_ff <= s2_in; s3_ff <= s3_in;
   end

endmodule

FILE: rtl/rar_queue.sv
// ----------------------------------------------------------------------------
// rar_queue
// Short first-in first-out queue of classified entries between the front
// and back ends.
// ----------------------------------------------------------------------------
module rar_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  rar_pkg::rar_wr_type    q_wr,
   output logic                   q_full,
   input  logic                   q_pop,
   output logic                   q_empty,
   output rar_pkg::rar_entry_type q_rd_entry
);
   import rar_pkg::*;

   rar_entry_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_wr, do_rd;

   assign q_full     = (cnt_ff == QCNT_W'(QDEPTH));
   assign q_empty    = (cnt_ff == '0);
   assign q_rd_entry = mem_ff[rd_ptr_ff];
   assign do_wr      = q_wr.valid && !q_full;
   assign do_rd      = q_pop && !q_empty;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_rd) rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_wr && !do_rd) cnt_in = cnt_ff + 1'b1;
      else if (do_rd && !do_wr) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_wr) mem_ff[wr_ptr_ff] <= q_wr.entry;
   end

endmodule

FILE: rtl/rar_back.sv
// ----------------------------------------------------------------------------
// rar_back
// Takes entries from the queue, finds the gcd with a binary gcd loop,
// divides numerator and denominator by it bit-serially and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module rar_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  rar_pkg::rar_entry_type        q_rd_entry,
   output logic                          empty,
   input  logic                          pop,
   output logic [rar_pkg::NUM_W-1:0]     rsp_res_num,
   output logic [rar_pkg::DEN_W-1:0]     rsp_res_den,
   output logic                          rsp_a_greater,
   output logic                          rsp_error
);
   import rar_pkg::*;

   typedef enum logic [3:0] {
      BK_IDLE = 4'b0001,
      BK_GCD  = 4'b0010,
      BK_DIV  = 4'b0100,
      BK_OUT  = 4'b1000
   } bk_state_type;

   bk_state_type     state_ff, state_in;
   rar_entry_type    ent_ff, ent_in;
   logic [MAG_W-1:0] gx_ff, gx_in, gy_ff, gy_in, g_ff, g_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MAG_W-1:0] nq_ff, nq_in, dq_ff, dq_in;
   logic [MAG_W:0]   nr_ff, nr_in, dr_ff, dr_in;
   logic             valid_ff, valid_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             gt_ff, gt_in, err_ff, err_in;

   logic [MAG_W:0]   nr_sh, dr_sh;
   logic             nr_ge, dr_ge, out_free;

   assign out_free = !valid_ff || pop;
   assign q_pop    = (state_ff == BK_IDLE) && !q_empty;

   // One restoring divide step on each lane
   assign nr_sh = {nr_ff[MAG_W-1:0], nq_ff[MAG_W-1]};
   assign dr_sh = {dr_ff[MAG_W-1:0], dq_ff[MAG_W-1]};
   assign nr_ge = (nr_sh >= {1'b0, g_ff});
   assign dr_ge = (dr_sh >= {1'b0, g_ff});

   always_comb begin
      state_in = state_ff;
      ent_in = ent_ff;
      gx_in = gx_ff; gy_in = gy_ff; g_in = g_ff; k_in = k_ff; cnt_in = cnt_ff;
      nq_in = nq_ff; dq_in = dq_ff; nr_in = nr_ff; dr_in = dr_ff;
      valid_in = valid_ff;
      num_in = num_ff; den_in = den_ff; gt_in = gt_ff; err_in = err_ff;
      if (pop) valid_in = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               ent_in = q_rd_entry;
               gx_in  = q_rd_entry.num_mag;
               gy_in  = q_rd_entry.den_mag;
               k_in   = '0;
               state_in = (q_rd_entry.kind == KIND_ARITH) ? BK_GCD : BK_OUT;
            end
         end
         // Binary gcd: one shift or one subtract per cycle
         BK_GCD: begin
            if (gx_ff == '0) begin
               g_in   = gy_ff << k_ff;
               nq_in  = ent_ff.num_mag;
               dq_in  = ent_ff.den_mag;
               nr_in  = '0;
               dr_in  = '0;
               cnt_in = CNT_W'(MAG_W - 1);
               state_in = BK_DIV;
            end else if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in = gx_ff >> 1;
               gy_in = gy_ff >> 1;
               k_in  = k_ff + 1'b1;
            end else if (!gx_ff[0]) begin
               gx_in = gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else if (gx_ff >= gy_ff) begin
               gx_in = gx_ff - gy_ff;
            end else begin
               gy_in = gy_ff - gx_ff;
            end
         end
         // Both quotients, one bit per cycle
         BK_DIV: begin
            nr_in = nr_ge ? (nr_sh - {1'b0, g_ff}) : nr_sh;
            dr_in = dr_ge ? (dr_sh - {1'b0, g_ff}) : dr_sh;
            nq_in = {nq_ff[MAG_W-2:0], nr_ge};
            dq_in = {dq_ff[MAG_W-2:0], dr_ge};
            if (cnt_ff == '0) state_in = BK_OUT;
            else cnt_in = cnt_ff - 1'b1;
         end
         BK_OUT: begin
            if (out_free) begin
               valid_in = 1'b1;
               num_in = '0; den_in = '0; gt_in = 1'b0; err_in = 1'b0;
               case (ent_ff.kind)
                  KIND_ERR: err_in = 1'b1;
                  KIND_CMP: gt_in = ent_ff.greater;
                  KIND_ARITH: begin
                     num_in = ent_ff.num_neg ? (~{1'b0, nq_ff} + 1'b1) : {1'b0, nq_ff};
                     den_in = ent_ff.den_neg ? (~dq_ff + 1'b1) : dq_ff;
                  end
                  default: err_in = 1'b1;
               endcase
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      ent_ff <= ent_in;
      gx_ff <= gx_in; gy_ff <= gy_in; g_ff <= g_in; k_ff <= k_in; cnt_ff <= cnt_in;
      nq_ff <= nq_in; dq_ff <= dq_in; nr_ff <= nr_in; dr_ff <= dr_in;
      num_ff <= num_in; den_ff <= den_in; gt_ff <= gt_in; err_ff <= err_in;
   end

   assign empty         = !valid_ff;
   assign rsp_res_num   = num_ff;
   assign rsp_res_den   = den_ff;
   assign rsp_a_greater = gt_ff;
   assign rsp_error     = err_ff;

endmodule

FILE: dv/rar_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rar_checker
// Watches the request and response queues of the rational arithmetic core,
// computes the exact reduced fraction of every accepted request and compares
// each response against the oldest pending one.
// ----------------------------------------------------------------------------
module rar_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic                          full,
   input  logic [2:0]                    req_type,
   input  logic [rar_pkg::WIDTH-1:0]     req_a_num,
   input  logic [rar_pkg::WIDTH-1:0]     req_a_den,
   input  logic [rar_pkg::WIDTH-1:0]     req_b_num,
   input  logic [rar_pkg::WIDTH-1:0]     req_b_den,
   input  logic                          empty,
   input  logic                          pop,
   input  logic [rar_pkg::NUM_W-1:0]     rsp_res_num,
   input  logic [rar_pkg::DEN_W-1:0]     rsp_res_den,
   input  logic                          rsp_a_greater,
   input  logic                          rsp_error,
   output int                            fail_count,
   output int                            pending_count
);
   import rar_pkg::*;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             greater;
      logic             error;
   } fraction_result_t;

   fraction_result_t expected_q[$];

   // Greatest common divisor of two magnitudes
   function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // Exact result of one request, computed with signed 64-bit arithmetic
   function automatic fraction_result_t compute_fraction(logic [2:0] op,
         logic signed [WIDTH-1:0] an, logic signed [WIDTH-1:0] ad,
         logic signed [WIDTH-1:0] bn, logic signed [WIDTH-1:0] bd);
      fraction_result_t r;
      longint n, d, diff;
      longint unsigned nm, dm, g;
      r = '0;
      if (op > OP_COMPARE || ad == 0 || (op != OP_REDUCE && bd == 0)) begin
         r.error = 1'b1;
         return r;
      end
      if (op == OP_COMPARE) begin
         diff = longint'(an) * bd - longint'(bn) * ad;
         r.greater = (diff != 0) && ((diff < 0) == ((ad < 0) != (bd < 0)));
         return r;
      end
      case (op)
         OP_REDUCE: begin n = an; d = ad; end
         OP_ADD:    begin n = longint'(an) * bd + longint'(ad) * bn; d = longint'(ad) * bd; end
         OP_SUB:    begin n = longint'(an) * bd - longint'(ad) * bn; d = longint'(ad) * bd; end
         OP_MUL:    begin n = longint'(an) * bn; d = longint'(ad) * bd; end
         default:   begin n = longint'(an) * bd; d = longint'(ad) * bn; end
      endcase
      if (d == 0) begin
         r.error = 1'b1;
         return r;
      end
      nm = (n < 0) ? -n : n;
      dm = (d < 0) ? -d : d;
      g = gcd_mag(nm, dm);
      n = n / longint'(g);
      d = d / longint'(g);
      r.num = n[NUM_W-1:0];
      r.den = d[DEN_W-1:0];
      return r;
   endfunction

   assign pending_count = expected_q.size();

   // Predict on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      fraction_result_t exp_r, got_r;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (push && !full)
            expected_q.push_back(compute_fraction(req_type, req_a_num, req_a_den,
                                                  req_b_num, req_b_den));
         if (pop && !empty) begin
            got_r = '{rsp_res_num, rsp_res_den, rsp_a_greater, rsp_error};
            if (expected_q.size() == 0) begin
               $display("%0t: response with none pending: num=%h den=%h gt=%b err=%b",
                        $time, got_r.num, got_r.den, got_r.greater, got_r.error);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (exp_r !== got_r) begin
                  $display("%0t: mismatch expected num=%h den=%h gt=%b err=%b",
                           $time, exp_r.num, exp_r.den, exp_r.greater, exp_r.error);
                  $display("%0t:          actual   num=%h den=%h gt=%b err=%b",
                           $time, got_r.num, got_r.den, got_r.greater, got_r.error);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random fraction requests into the rational arithmetic
// core with random idling on both queues and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import rar_pkg::*;

   localparam int N_RANDOM = 1700;
   localparam int CYCLE_LIMIT = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic [2:0] req_type = '0;
   logic [WIDTH-1:0] req_a_num = '0, req_a_den = '0, req_b_num = '0, req_b_den = '0;
   logic [NUM_W-1:0] rsp_res_num;
   logic [DEN_W-1:0] rsp_res_den;
   logic rsp_a_greater, rsp_error;
   int fail_count, pending_count;
   int cycle_count = 0;
   bit calm_phase = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rational_arith_reduce_core u_top (.*);

   rar_checker u_checker (.*);

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Operand picker: corners often, small values often, anything else
   function automatic logic [WIDTH-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return WIDTH'($urandom_range(0, 2)) - 16'd1;
         4, 5: return WIDTH'($signed($urandom_range(0, 40)) - 20);
         default: return WIDTH'($urandom);
      endcase
   endfunction

   // Offer one request transaction and wait until it is accepted;
   // push stays high so the next request can follow right away
   task automatic send_request(logic [2:0] op, logic [WIDTH-1:0] an, logic [WIDTH-1:0] ad,
                               logic [WIDTH-1:0] bn, logic [WIDTH-1:0] bd);
      req_type  <= op;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      push      <= 1'b1;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   // Response side: random stalls, one long hold-off early on
   initial begin
      int stall_count;
      @(negedge clock);
      while (reset) @(negedge clock);
      stall_count = 0;
      pop <= 1'b0;
      while (stall_count < 3000) begin
         @(negedge clock);
         stall_count++;
      end
      forever begin
         if (!calm_phase && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         pop <= 1'b1;
         @(negedge clock);
      end
   end

   // Request side
   initial begin
      logic [WIDTH-1:0] corner[4];
      int op, i;
      corner = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // Directed: every code with extreme operands, zero denominators, zero numerators
      for (op = 0; op < 8; op++)
         send_request(3'(op), 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
      for (op = 0; op < 6; op++)
         send_request(3'(op), 16'h7fff, 16'h8001, 16'hffff, 16'h7fff);
      send_request(OP_ADD, 16'd3, 16'd0, 16'd1, 16'd2);
      send_request(OP_SUB, 16'd3, 16'd4, 16'd1, 16'd0);
      send_request(OP_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
      send_request(OP_REDUCE, 16'd0, 16'hfffb, 16'd0, 16'd0);
      send_request(OP_MUL, 16'd0, 16'd6, 16'd5, 16'd7);
      send_request(OP_COMPARE, 16'd1, 16'd2, 16'd2, 16'd4);
      send_request(OP_COMPARE, 16'd1, 16'hfffe, 16'd1, 16'd3);
      send_request(OP_REDUCE, 16'hffd6, 16'h0038, 16'd0, 16'd0);
      send_request(OP_ADD, corner[$urandom_range(0,3)], 16'h7fff, 16'h8000, 16'h7fff);
      // Random part; the last stretch runs without idling
      for (i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM - 200) calm_phase = 1'b1;
         idle_gap();
         send_request(($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5)),
                      pick_operand(), pick_operand(), pick_operand(), pick_operand());
      end
      push <= 1'b0;
      // Drain, then let any work in flight settle
      while (pending_count != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
